// ===== sv/svcb_pkg.sv =====
// Package of the segmental Viterbi character boundary block.
// Holds the field widths, the memory entry types and the controller states.
// Depends on nothing.
package svcb_pkg;

    localparam int MaxFrames = 32;
    localparam int MaxChars  = 16;
    localparam int FrameW    = 5;
    localparam int PosW      = 4;
    localparam int TW        = 6;
    localparam int KW        = 5;
    localparam int SegAddrW  = PosW + 2 * FrameW;
    localparam int DpAddrW   = FrameW + PosW;
    localparam int InDataW   = 64;
    localparam int OutDataW  = 48;

    localparam logic OpLoad   = 1'b0;
    localparam logic OpDecode = 1'b1;

    typedef struct packed {
        logic signed [31:0] score;
        logic               finite;
    } t_score;

    typedef struct packed {
        logic signed [31:0] score;
        logic               finite;
        logic [FrameW-1:0]  start;
        logic               valid;
    } t_dp;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EMPTY  = 10'b00_0000_0010,
        S_COPY   = 10'b00_0000_0100,
        S_KSTART = 10'b00_0000_1000,
        S_CALC   = 10'b00_0001_0000,
        S_FLUSH  = 10'b00_0010_0000,
        S_WRITE  = 10'b00_0100_0000,
        S_TRD    = 10'b00_1000_0000,
        S_TWT    = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

endpackage

// ===== sv/segmental_viterbi_char_boundaries.sv =====
// Top level of the segmental Viterbi character boundary block.
// Holds the segment score memory, the level building memory and the controller.
// Depends on svcb_pkg.
//
// Usage: items enter on the s_axis channel. With tuser low an item writes one
// segment score entry; loads stream at one item per cycle while no decode
// runs. With tuser high it starts a decode of T frames and K characters.
// Results leave on the m_axis channel: K items in ascending character order,
// tlast on the final one, or a single log-zero item when K is zero.
// A decode runs from the two memories, each read through a registered port:
// it copies position 0, fills each (k, t) cell with one pair of reads per
// start frame plus a drain and a write back, traces back, and then emits
// each result while the receiver is ready.
// The input is not ready during a decode; it is ready again once the last
// result is in the output register, even if that result still waits.
// A stalled receiver holds the output register and halts result emission.
// Reset clears the controller and the output valid; the memories are not
// cleared and entries not loaded since reset must not be referenced.
module segmental_viterbi_char_boundaries (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // char_pos, seg_start, seg_end, seg_score, seg_finite, num_frames, num_chars
    input  logic [svcb_pkg::InDataW-1:0]  s_axis_tdata,
    // operation
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_pos, boundary_end, best_total, total_finite
    output logic [svcb_pkg::OutDataW-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import svcb_pkg::*;

    t_state r_state;

    logic [PosW-1:0]   in_pos;
    logic [FrameW-1:0] in_start;
    logic [FrameW-1:0] in_end;
    t_score            in_score;
    logic [TW-1:0]     in_t;
    logic [KW-1:0]     in_k;
    logic [TW-1:0]     t_clamp;
    logic [KW-1:0]     k_clamp;

    assign in_pos         = s_axis_tdata[3:0];
    assign in_start       = s_axis_tdata[8:4];
    assign in_end         = s_axis_tdata[13:9];
    assign in_score.score = s_axis_tdata[45:14];
    assign in_score.finite = s_axis_tdata[46];
    assign in_t           = s_axis_tdata[52:47];
    assign in_k           = s_axis_tdata[57:53];
    assign t_clamp = (in_t > TW'(MaxFrames)) ? TW'(MaxFrames) : in_t;
    assign k_clamp = (in_k > KW'(MaxChars)) ? KW'(MaxChars) : in_k;

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Segment score memory.
    t_score seg_mem [2**SegAddrW];
    t_score r_seg_rd;
    logic [SegAddrW-1:0] seg_raddr;
    logic seg_we;
    assign seg_we = accept && (s_axis_tuser == OpLoad);

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            seg_mem[{in_pos, in_start, in_end}] <= in_score;
        end
        r_seg_rd <= seg_mem[seg_raddr];
    end

    // Level building memory: best score and back pointer per (t, k).
    t_dp dp_mem [2**DpAddrW];
    t_dp r_dp_rd;
    logic [DpAddrW-1:0] dp_raddr;
    logic [DpAddrW-1:0] dp_waddr;
    t_dp dp_wdata;
    logic dp_we;

    always_ff @(posedge i_clk) begin
        if (dp_we) begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        r_dp_rd <= dp_mem[dp_raddr];
    end

    logic [TW-1:0]     r_t_len;
    logic [KW-1:0]     r_k_len;
    logic [KW-1:0]     r_k;
    logic [FrameW-1:0] r_t;
    logic [FrameW-1:0] r_s;
    logic              r_cv;
    logic [FrameW-1:0] r_ct;
    logic              r_pv;
    logic [FrameW-1:0] r_ps;
    logic              r_have;
    logic signed [31:0] r_best;
    logic [FrameW-1:0] r_arg;
    logic              r_first;
    t_score            r_total;
    logic [FrameW-1:0] r_bound [MaxChars];
    logic [PosW-1:0]   r_j;
    logic              r_ovalid;
    logic [OutDataW-1:0] r_odata;
    logic              r_olast;

    logic [PosW-1:0]   k_idx;
    logic [PosW-1:0]   kp_idx;
    assign k_idx  = r_k[PosW-1:0];
    assign kp_idx = PosW'(r_k - KW'(1));

    always_comb begin
        seg_raddr = '0;
        dp_raddr  = '0;
        case (r_state)
            S_COPY:  seg_raddr = {PosW'(0), FrameW'(0), r_t};
            S_CALC: begin
                seg_raddr = {k_idx, FrameW'(r_s + FrameW'(1)), r_t};
                dp_raddr  = {r_s, kp_idx};
            end
            S_TRD:   dp_raddr = {r_t, k_idx};
            default: ;
        endcase
    end

    always_comb begin
        dp_we    = 1'b0;
        dp_waddr = {r_ct, PosW'(0)};
        dp_wdata = '{score: r_seg_rd.score, finite: r_seg_rd.finite,
                     start: '0, valid: 1'b0};
        if (r_cv) begin
            dp_we = 1'b1;
        end else if (r_state == S_WRITE) begin
            dp_we    = 1'b1;
            dp_waddr = {r_t, k_idx};
            dp_wdata = '{score: r_have ? r_best : 32'sd0, finite: r_have,
                         start: r_arg, valid: r_have};
        end
    end

    logic signed [32:0] sum_w;
    logic signed [31:0] sum_sat;
    assign sum_w = {r_dp_rd.score[31], r_dp_rd.score}
                 + {r_seg_rd.score[31], r_seg_rd.score};
    always_comb begin
        if (sum_w[32] != sum_w[31]) begin
            sum_sat = sum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sum_sat = sum_w[31:0];
        end
    end

    logic cell_ok;
    assign cell_ok = ({1'b0, r_t} >= TW'(r_k) + TW'(1));

    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;

    logic out_load;
    assign out_load = out_free && ((r_state == S_EMPTY) || (r_state == S_EMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cv     <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_cv <= (r_state == S_COPY);
            r_pv <= (r_state == S_CALC);
            if (r_pv && r_dp_rd.finite && r_seg_rd.finite) begin
                if (!r_have || sum_sat > r_best) begin
                    r_have <= 1'b1;
                    r_best <= sum_sat;
                    r_arg  <= r_ps;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && s_axis_tuser == OpDecode) begin
                        r_t_len <= t_clamp;
                        r_k_len <= k_clamp;
                        r_t     <= FrameW'(1);
                        r_k     <= KW'(1);
                        if (k_clamp == '0) begin
                            r_state <= S_EMPTY;
                        end else if (t_clamp >= TW'(2)) begin
                            r_state <= S_COPY;
                        end else begin
                            r_state <= S_KSTART;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_odata  <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_COPY: begin
                    r_ct <= r_t;
                    if (TW'(r_t) + TW'(1) == r_t_len) begin
                        r_state <= S_KSTART;
                    end else begin
                        r_t <= r_t + FrameW'(1);
                    end
                end
                S_KSTART: begin
                    if (r_k >= r_k_len) begin
                        r_k     <= r_k_len - KW'(1);
                        r_t     <= (r_t_len != '0) ? FrameW'(r_t_len - TW'(1)) : '0;
                        r_first <= 1'b1;
                        r_state <= S_TRD;
                    end else if (TW'(r_k) + TW'(1) >= r_t_len) begin
                        r_k <= r_k + KW'(1);
                    end else begin
                        r_t     <= FrameW'(r_k + KW'(1));
                        r_s     <= FrameW'(r_k);
                        r_have  <= 1'b0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_ps <= r_s;
                    if (r_s + FrameW'(1) == r_t) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_s <= r_s + FrameW'(1);
                    end
                end
                S_FLUSH: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (TW'(r_t) + TW'(1) < r_t_len) begin
                        r_t     <= r_t + FrameW'(1);
                        r_s     <= FrameW'(r_k);
                        r_have  <= 1'b0;
                        r_state <= S_CALC;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_KSTART;
                    end
                end
                S_TRD: begin
                    r_state <= S_TWT;
                end
                S_TWT: begin
                    r_bound[k_idx] <= r_t;
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_total.finite <= cell_ok && r_dp_rd.finite;
                        r_total.score  <= (cell_ok && r_dp_rd.finite)
                                        ? r_dp_rd.score : 32'sd0;
                    end
                    if (r_k != '0 && cell_ok && r_dp_rd.valid) begin
                        r_t <= r_dp_rd.start;
                    end
                    if (r_k == '0) begin
                        r_j     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_TRD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_odata  <= {6'b0, r_total.finite, r_total.score,
                                     r_bound[r_j], r_j};
                        r_olast  <= (KW'(r_j) == r_k_len - KW'(1));
                        if (KW'(r_j) == r_k_len - KW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + PosW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    a_pend_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state == S_CALC))
        else $error("read pair pending without an issue");
    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !r_pv)
        else $error("write back before the last read pair was folded in");
    a_copy_not_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_state != S_CALC))
        else $error("row copy overlaps the recursion");
    a_trace_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWT) |-> $past(r_state == S_TRD))
        else $error("trace step without its read");

endmodule

// ===== test/tb_segmental_viterbi_char_boundaries.sv =====
// Self-checking testbench of the segmental Viterbi character boundary block.
// The directed table and random runs are checked against table values or a predictor.
// Depends on svcb_pkg and segmental_viterbi_char_boundaries.
`timescale 1ns / 100ps

module tb_segmental_viterbi_char_boundaries;
    import svcb_pkg::*;

    typedef struct {
        logic              op;
        logic [63:0]       data;
        bit                typed;
        logic [4:0]        t_bend;
        logic signed [31:0] t_total;
        logic              t_fin;
    } t_item;

    typedef struct {
        logic [3:0]         pos;
        logic [4:0]         bend;
        logic signed [31:0] total;
        logic               fin;
        logic               last;
    } t_bound;

    typedef struct {
        logic               op;
        logic [3:0]         pos;
        logic [4:0]         st;
        logic [4:0]         en;
        logic signed [31:0] score;
        logic               fin;
        logic [5:0]         frames;
        logic [4:0]         chars;
        bit                 typed;
        logic [4:0]         t_bend;
        logic signed [31:0] t_total;
        logic               t_fin;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_item  stim_q[$];
    t_bound bound_q[$];
    int     accepted = 0;
    int     errors = 0;
    int     n_dir = 0;
    bit     dir_done = 1'b0;
    bit     hold_off = 1'b0;
    int     rx_cnt = 0;

    logic signed [31:0] seg_val[MaxChars][MaxFrames][MaxFrames];
    bit                 seg_fin[MaxChars][MaxFrames][MaxFrames];
    bit                 gen_loaded[MaxChars][MaxFrames][MaxFrames];

    segmental_viterbi_char_boundaries dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] pack_in(logic [3:0] pos, logic [4:0] st, logic [4:0] en,
            logic [31:0] score, logic fin, logic [5:0] frames, logic [4:0] chars);
        return {6'b0, chars, frames, fin, score, en, st, pos};
    endfunction

    function automatic logic [31:0] rand_score();
        case ($urandom % 5)
            0: return $urandom;
            1: return 32'($urandom_range(0, 262143)) - 32'sd131072;
            2: return ($urandom % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'(($urandom_range(0, 2) - 1) * 65536);
        endcase
    endfunction

    task automatic add_item(logic op, logic [63:0] data);
        t_item it;
        it.op = op;
        it.data = data;
        it.typed = 1'b0;
        it.t_bend = '0;
        it.t_total = '0;
        it.t_fin = 1'b0;
        stim_q = {stim_q, it};
        if (op == OpLoad)
            gen_loaded[data[3:0]][data[8:4]][data[13:9]] = 1'b1;
    endtask

    task automatic need_entry(int k, int s, int e, bit fresh_only);
        if (!gen_loaded[k][s][e] || (!fresh_only && $urandom % 3 == 0))
            add_item(OpLoad, pack_in(4'(k), 5'(s), 5'(e), rand_score(),
                                     ($urandom % 8) != 0, 6'($urandom), 5'($urandom)));
    endtask

    // Loads each entry the decode reads that is not yet loaded, then issues the decode.
    task automatic gen_word(int frames, int chars, bit fresh_only);
        int tc, kc;
        tc = frames > MaxFrames ? MaxFrames : frames;
        kc = chars > MaxChars ? MaxChars : chars;
        if (kc > 0) begin
            for (int t = 1; t < tc; t++)
                need_entry(0, 0, t, fresh_only);
            for (int k = 1; k < kc; k++)
                for (int t = k + 1; t < tc; t++)
                    for (int s = k; s < t; s++)
                        need_entry(k, s + 1, t, fresh_only);
        end
        add_item(OpDecode, pack_in(4'($urandom), 5'($urandom), 5'($urandom), $urandom,
                                   1'($urandom), 6'(frames), 5'(chars)));
    endtask

    task automatic predict_decode(int frames, int chars);
        logic signed [31:0] bsc[MaxFrames][MaxChars];
        bit                 bfin[MaxFrames][MaxChars];
        int                 bst[MaxFrames][MaxChars];
        bit                 bval[MaxFrames][MaxChars];
        int                 tc, kc, t, arg;
        bit                 have;
        longint             sum, best;
        logic signed [31:0] total;
        bit                 tfin;
        int                 bend[MaxChars];
        t_bound             r;
        tc = frames > MaxFrames ? MaxFrames : frames;
        kc = chars > MaxChars ? MaxChars : chars;
        if (kc == 0) begin
            r = '{pos: 0, bend: 0, total: 0, fin: 0, last: 1};
            bound_q = {bound_q, r};
            return;
        end
        for (int i = 0; i < MaxFrames; i++)
            for (int j = 0; j < MaxChars; j++) begin
                bsc[i][j] = 0; bfin[i][j] = 0; bst[i][j] = 0; bval[i][j] = 0;
            end
        for (int i = 1; i < tc; i++) begin
            bsc[i][0] = seg_val[0][0][i];
            bfin[i][0] = seg_fin[0][0][i];
        end
        for (int k = 1; k < kc; k++)
            for (int i = k + 1; i < tc; i++) begin
                have = 0; best = 0; arg = 0;
                for (int s = k; s < i; s++) begin
                    if (!bfin[s][k-1] || !seg_fin[k][s+1][i])
                        continue;
                    sum = longint'(bsc[s][k-1]) + longint'(seg_val[k][s+1][i]);
                    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                    if (!have || sum > best) begin
                        have = 1; best = sum; arg = s;
                    end
                end
                bsc[i][k] = have ? 32'(best) : 0;
                bfin[i][k] = have;
                bst[i][k] = arg;
                bval[i][k] = have;
            end
        if (tc >= 1) begin
            total = bsc[tc-1][kc-1];
            tfin = bfin[tc-1][kc-1];
        end else begin
            total = 0;
            tfin = 0;
        end
        if (!tfin)
            total = 0;
        t = (tc >= 1) ? tc - 1 : 0;
        for (int k = kc - 1; k >= 0; k--) begin
            bend[k] = t;
            if (k > 0 && bval[t][k])
                t = bst[t][k];
        end
        for (int k = 0; k < kc; k++) begin
            r = '{pos: 4'(k), bend: 5'(bend[k]), total: total, fin: tfin,
                  last: k == kc - 1};
            bound_q = {bound_q, r};
        end
    endtask

    always @(posedge i_clk) begin
        t_item  it;
        t_bound got, want;
        int     cnt;
        if (s_axis_tvalid && s_axis_tready) begin
            it = stim_q[accepted];
            accepted <= accepted + 1;
            if (s_axis_tuser == OpLoad) begin
                seg_val[s_axis_tdata[3:0]][s_axis_tdata[8:4]][s_axis_tdata[13:9]] =
                    s_axis_tdata[45:14];
                seg_fin[s_axis_tdata[3:0]][s_axis_tdata[8:4]][s_axis_tdata[13:9]] =
                    s_axis_tdata[46];
            end else if (it.typed) begin
                cnt = s_axis_tdata[57:53] > MaxChars ? MaxChars : s_axis_tdata[57:53];
                if (cnt == 0)
                    cnt = 1;
                for (int k = 0; k < cnt; k++) begin
                    want = '{pos: 4'(k), bend: it.t_bend, total: it.t_total,
                             fin: it.t_fin, last: k == cnt - 1};
                    bound_q = {bound_q, want};
                end
            end else begin
                predict_decode(s_axis_tdata[52:47], s_axis_tdata[57:53]);
            end
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{pos: m_axis_tdata[3:0], bend: m_axis_tdata[8:4],
                    total: m_axis_tdata[40:9], fin: m_axis_tdata[41], last: m_axis_tlast};
            if (bound_q.size() == 0) begin
                $display("%0t: unexpected result pos=%0d bend=%0d total=%0d fin=%0d",
                         $time, got.pos, got.bend, got.total, got.fin);
                errors++;
            end else begin
                want = bound_q.pop_front();
                if (got.pos !== want.pos || got.bend !== want.bend
                        || got.total !== want.total || got.fin !== want.fin
                        || got.last !== want.last) begin
                    $display("%0t: mismatch expected pos=%0d bend=%0d total=%0d fin=%0d last=%0d",
                             $time, want.pos, want.bend, want.total, want.fin, want.last);
                    $display("%0t:          actual   pos=%0d bend=%0d total=%0d fin=%0d last=%0d",
                             $time, got.pos, got.bend, got.total, got.fin, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (rx_cnt[8])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= (rx_cnt % 7 != 0) && ($urandom_range(0, 4) != 0);
    end

    initial begin
        wait (dir_done);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("** segmental_viterbi_char_boundaries: FAILED **");
        $finish;
    end

    initial begin
        t_row dir_tab[22];
        t_item it;
        int burst, gap;
        dir_tab = '{
            '{OpDecode, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            '{OpDecode, 15, 31, 31, 32'hFFFF_FFFF, 1, 63, 0, 1, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 0, 3, 1, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 1, 2, 1, 0, 0, 0},
            '{OpLoad, 0, 0, 1, 32'sh7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 0, 0, 2, 32'sh8000_0000, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 1, 2, 2, 32'sh7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 3, 2, 0, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 2, 1, 0, 0, 0, 0},
            '{OpLoad, 0, 0, 1, 32'sh8000_0000, 1, 63, 31, 0, 0, 0, 0},
            '{OpLoad, 1, 2, 2, 32'sh8000_0000, 1, 0, 0, 0, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 3, 2, 0, 0, 0, 0},
            '{OpLoad, 1, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 3, 2, 0, 0, 0, 0},
            '{OpLoad, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 0, 0, 2, 2, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 0, 0, 3, 0, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 1, 2, 2, 5, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 1, 2, 3, 3, 1, 0, 0, 0, 0, 0, 0},
            '{OpLoad, 1, 3, 3, 2, 1, 0, 0, 0, 0, 0, 0},
            '{OpDecode, 0, 0, 0, 0, 0, 4, 2, 0, 0, 0, 0},
            '{OpLoad, 15, 31, 31, 32'sh7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0}
        };
        foreach (dir_tab[i]) begin
            add_item(dir_tab[i].op, pack_in(dir_tab[i].pos, dir_tab[i].st, dir_tab[i].en,
                     dir_tab[i].score, dir_tab[i].fin, dir_tab[i].frames, dir_tab[i].chars));
            stim_q[$].typed = dir_tab[i].typed;
            stim_q[$].t_bend = dir_tab[i].t_bend;
            stim_q[$].t_total = dir_tab[i].t_total;
            stim_q[$].t_fin = dir_tab[i].t_fin;
        end
        n_dir = stim_q.size();
        while (stim_q.size() < 170) begin
            case ($urandom % 6)
                0: add_item(OpLoad, {$urandom, $urandom} & 64'h03FF_FFFF_FFFF_FFFE);
                1: gen_word($urandom_range(0, 10), $urandom_range(0, 3), 1'b0);
                default: gen_word($urandom_range(0, 8), $urandom_range(0, 4), 1'b0);
            endcase
        end
        gen_word(63, 1, 1'b1);
        gen_word(3, 31, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst = 0;
        for (int i = 0; i < stim_q.size(); i++) begin
            if (burst == 0) begin
                gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 20);
            end
            burst--;
            it = stim_q[i];
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= it.op;
            s_axis_tdata <= it.data;
            do @(posedge i_clk); while (!s_axis_tready);
            if (i == n_dir - 1)
                dir_done = 1'b1;
        end
        s_axis_tvalid <= 1'b0;
        while (accepted < stim_q.size() || bound_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("** segmental_viterbi_char_boundaries: PASSED **");
        else
            $display("** segmental_viterbi_char_boundaries: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/svcb_pkg.sv
sv/segmental_viterbi_char_boundaries.sv
test/tb_segmental_viterbi_char_boundaries.sv
